[rtl/core/lrx_pkg.sv]
// ----------------------------------------------------------------------------
// lrx_pkg
// Shared types and constants of the Linkwitz-Riley crossover core: sample and
// coefficient widths, the register map and the coefficient reset values.
// ----------------------------------------------------------------------------
package lrx_pkg;

    localparam int DATA_W  = 32;            // sample and coefficient width
    localparam int PROD_W  = 2 * DATA_W;    // full product and accumulator width
    localparam int FRAC_W  = 30;            // Q2.30 fraction bits
    localparam int TAPS    = 5;             // multiply-accumulates per biquad
    localparam int NUM_REG = 8;             // configuration registers
    localparam int CIDX_W  = 4;             // width of the register index port
    localparam int REG_W   = 3;             // width of an index into the register file

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0] t_acc;

    // Register map.
    localparam logic [REG_W-1:0] REG_HIGH_B0 = 3'd0;
    localparam logic [REG_W-1:0] REG_HIGH_B1 = 3'd1;
    localparam logic [REG_W-1:0] REG_HIGH_B2 = 3'd2;
    localparam logic [REG_W-1:0] REG_LOW_B0  = 3'd3;
    localparam logic [REG_W-1:0] REG_LOW_B1  = 3'd4;
    localparam logic [REG_W-1:0] REG_LOW_B2  = 3'd5;
    localparam logic [REG_W-1:0] REG_NEG_A1  = 3'd6;
    localparam logic [REG_W-1:0] REG_NEG_A2  = 3'd7;

    localparam t_sample COEF_RESET [NUM_REG] = '{
        32'sd1034714276,
        -32'sd2069428553,
        32'sd1034714276,
        32'sd709506,
        32'sd1419012,
        32'sd709506,
        32'sd2068009541,
        -32'sd997105741
    };

endpackage

[rtl/core/linkwitz_riley_crossover_core.sv]
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover_core
// Fourth-order Linkwitz-Riley crossover built on one shared 32x32 multiplier
// and a 64-bit accumulator, stepped by a small sequencer through the biquads.
// ----------------------------------------------------------------------------
// Sequencing: per biquad the single multiplier runs five multiply/accumulate
//   steps, each a multiply state then an accumulate state, plus one write-back;
//   each channel has SECTIONS biquads. No new sample pair is taken until the
//   result is handed to the output register, which waits while it holds an untaken pair.
// Reset (synchronous, active low) clears all filter histories, loads the
//   default coefficients and empties the output register.
module linkwitz_riley_crossover_core
    import lrx_pkg::*;
#(
    parameter int SECTIONS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream. tdata: [31:0] left_sample, [63:32] right_sample.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [2*DATA_W-1:0] i_s_axis_tdata,
    // Output stream. tdata: [31:0] left_high, [63:32] right_low.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [2*DATA_W-1:0] o_m_axis_tdata,
    // Configuration write channel. Indexes past the register map are ignored.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [DATA_W-1:0]   i_cfg_data
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);
    localparam logic [2:0] LAST_TAP = 3'(TAPS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input transfer
    localparam logic [2:0] ST_MUL  = 3'd1;  // multiplier produces one product
    localparam logic [2:0] ST_ACC  = 3'd2;  // product added into the accumulator
    localparam logic [2:0] ST_WB   = 3'd3;  // section output and history update
    localparam logic [2:0] ST_DONE = 3'd4;  // hand the pair to the output register

    logic [2:0]       r_state, n_state;
    logic [SEC_W-1:0] r_sec;        // current section
    logic             r_ch;         // 0: left/highpass, 1: right/lowpass
    logic [2:0]       r_k;          // current tap of the biquad

    t_sample r_coef [NUM_REG];

    // Section histories, indexed by channel and section.
    t_sample r_x1 [2][SECTIONS];
    t_sample r_x2 [2][SECTIONS];
    t_sample r_y1 [2][SECTIONS];
    t_sample r_y2 [2][SECTIONS];

    // Running sample of each channel: the input, then each section's output.
    t_sample r_xl;
    t_sample r_xr;

    t_acc    r_prod;
    t_acc    r_acc;

    logic                r_out_valid;
    logic [2*DATA_W-1:0] r_out_data;

    logic       in_xfer;
    logic       out_xfer;
    logic       out_free;
    logic [REG_W-1:0] coef_sel;
    t_sample    coef_op;
    t_sample    data_op;
    t_sample    x_cur;
    t_sample    y_new;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;
    // The output register can take a new pair when it is empty or draining.
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // Operand selection for the shared multiplier. The feedforward taps take
    // the channel's own coefficients; the feedback taps are shared.
    always_comb begin
        x_cur = r_ch ? r_xr : r_xl;
        case (r_k)
            3'd0: begin
                coef_sel = r_ch ? REG_LOW_B0 : REG_HIGH_B0;
                data_op  = x_cur;
            end
            3'd1: begin
                coef_sel = r_ch ? REG_LOW_B1 : REG_HIGH_B1;
                data_op  = r_x1[r_ch][r_sec];
            end
            3'd2: begin
                coef_sel = r_ch ? REG_LOW_B2 : REG_HIGH_B2;
                data_op  = r_x2[r_ch][r_sec];
            end
            3'd3: begin
                coef_sel = REG_NEG_A1;
                data_op  = r_y1[r_ch][r_sec];
            end
            default: begin
                coef_sel = REG_NEG_A2;
                data_op  = r_y2[r_ch][r_sec];
            end
        endcase
        coef_op = r_coef[coef_sel];
        // Section output: bits 30..61 of the exact sum, wrapping.
        y_new = r_acc[FRAC_W +: DATA_W];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = (r_k == LAST_TAP) ? ST_WB : ST_MUL;
            end
            ST_WB: begin
                n_state = (r_ch && r_sec == LAST_SEC) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, coefficients and histories.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sec       <= '0;
            r_ch        <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REG; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
            for (int c = 0; c < 2; c++) begin
                for (int s = 0; s < SECTIONS; s++) begin
                    r_x1[c][s] <= '0;
                    r_x2[c][s] <= '0;
                    r_y1[c][s] <= '0;
                    r_y2[c][s] <= '0;
                end
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready && i_cfg_index < CIDX_W'(NUM_REG)) begin
                r_coef[i_cfg_index[REG_W-1:0]] <= i_cfg_data;
            end

            case (r_state)
                ST_IDLE: begin
                    r_sec <= '0;
                    r_ch  <= 1'b0;
                    r_k   <= '0;
                end
                ST_ACC: begin
                    if (r_k != LAST_TAP) begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_WB: begin
                    r_x2[r_ch][r_sec] <= r_x1[r_ch][r_sec];
                    r_x1[r_ch][r_sec] <= x_cur;
                    r_y2[r_ch][r_sec] <= r_y1[r_ch][r_sec];
                    r_y1[r_ch][r_sec] <= y_new;
                    r_k  <= '0;
                    r_ch <= !r_ch;
                    if (r_ch && r_sec != LAST_SEC) begin
                        r_sec <= r_sec + SEC_W'(1);
                    end
                end
                default: begin
                end
            endcase

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; they carry no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_xl <= i_s_axis_tdata[DATA_W-1:0];
                    r_xr <= i_s_axis_tdata[2*DATA_W-1:DATA_W];
                end
            end
            ST_MUL: begin
                r_prod <= coef_op * data_op;
            end
            ST_ACC: begin
                // The first tap starts a fresh sum; the rest add to it modulo 2^64.
                r_acc <= (r_k == 3'd0) ? r_prod : r_acc + r_prod;
            end
            ST_WB: begin
                if (r_ch) begin
                    r_xr <= y_new;
                end else begin
                    r_xl <= y_new;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= {r_xr, r_xl};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/lrx_checker.sv]
// ----------------------------------------------------------------------------
// lrx_checker
// Port-level checks of the crossover core, bound to the core module.
// ----------------------------------------------------------------------------
module lrx_checker
    import lrx_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [2*DATA_W-1:0] o_m_axis_tdata,
    input logic                o_cfg_ready
);

    // An offered result stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // The core works on one sample pair at a time.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while a pair is in progress");

    // A new result appears exactly when the core becomes free again.
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $rose(o_s_axis_tready))
        else $error("result and input ready out of step");

    // Reset leaves the core idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready && o_cfg_ready)
        else $error("core not idle after reset");

endmodule

bind linkwitz_riley_crossover_core lrx_checker u_lrx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_cfg_ready     (o_cfg_ready)
);
